FILE: design/bsl_pkg.sv
// package for the byte stream lexer: types, codes, character constants and helpers
package bsl_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT   = 16;
   localparam int MAX_RECORDS           = 3;
   localparam int QUEUE_DEPTH           = 4;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_STRING,
      MODE_SYMBOL
   } lex_mode_type;

   // token type codes
   localparam logic [4:0] TOK_LPAREN   = 5'd0;
   localparam logic [4:0] TOK_RPAREN   = 5'd1;
   localparam logic [4:0] TOK_LBRACE   = 5'd2;
   localparam logic [4:0] TOK_RBRACE   = 5'd3;
   localparam logic [4:0] TOK_LBRACKET = 5'd4;
   localparam logic [4:0] TOK_RBRACKET = 5'd5;
   localparam logic [4:0] TOK_ASSIGN   = 5'd6;
   localparam logic [4:0] TOK_ADD      = 5'd7;
   localparam logic [4:0] TOK_SUB      = 5'd8;
   localparam logic [4:0] TOK_DIV      = 5'd9;
   localparam logic [4:0] TOK_MUL      = 5'd10;
   localparam logic [4:0] TOK_SEMI     = 5'd11;
   localparam logic [4:0] TOK_GREATER  = 5'd12;
   localparam logic [4:0] TOK_SEPARATOR = 5'd13;
   localparam logic [4:0] TOK_NUMERAL  = 5'd14;
   localparam logic [4:0] TOK_QUOTED   = 5'd15;
   localparam logic [4:0] TOK_SYMBOL   = 5'd16;

   // record kinds
   localparam logic REC_TEXT = 1'b0;
   localparam logic REC_END  = 1'b1;

   // characters
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_VTAB     = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED = 8'h0C;
   localparam logic [7:0] CHAR_RETURN   = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_STAR     = 8'h2A;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
   localparam logic [7:0] CHAR_GREATER  = 8'h3E;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;

   typedef struct packed {
      logic        record_kind;
      logic [7:0]  token_byte;
      logic [4:0]  token_type;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] token_length;
   } record_type;

   typedef struct packed {
      logic [1:0]                        count;
      record_type [MAX_RECORDS-1:0]      recs;
   } entry_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } punct_type;

   function automatic logic [15:0] cap16(input logic [31:0] v);
      cap16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic punct_type punct_lookup(input logic [7:0] b);
      punct_type p;
      p.hit  = 1'b1;
      p.code = TOK_LPAREN;
      case (b)
         CHAR_LPAREN:   p.code = TOK_LPAREN;
         CHAR_RPAREN:   p.code = TOK_RPAREN;
         CHAR_LBRACE:   p.code = TOK_LBRACE;
         CHAR_RBRACE:   p.code = TOK_RBRACE;
         CHAR_LBRACKET: p.code = TOK_LBRACKET;
         CHAR_RBRACKET: p.code = TOK_RBRACKET;
         CHAR_EQUAL:    p.code = TOK_ASSIGN;
         CHAR_PLUS:     p.code = TOK_ADD;
         CHAR_MINUS:    p.code = TOK_SUB;
         CHAR_SLASH:    p.code = TOK_DIV;
         CHAR_STAR:     p.code = TOK_MUL;
         CHAR_SEMI:     p.code = TOK_SEMI;
         CHAR_GREATER:  p.code = TOK_GREATER;
         CHAR_COMMA:    p.code = TOK_SEPARATOR;
         default:       p.hit  = 1'b0;
      endcase
      return p;
   endfunction

endpackage

FILE: design/bsl_if.sv
// valid/ready channel interfaces for the lexer's byte input and record output
interface bsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bsl_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [7:0]  token_byte;
   logic [4:0]  token_type;
   logic [15:0] start_line;
   logic [15:0] start_column;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output record_kind, output token_byte, output token_type,
                   output start_line, output start_column, output token_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input record_kind, input token_byte, input token_type,
                   input start_line, input start_column, input token_length,
                   input last_of_run, output ready);
endinterface

FILE: design/bsl_front.sv
// lexer front end: classifies each byte, keeps lexer state, builds the records of one byte
module bsl_front #(
   parameter int POSITION_BITS = bsl_pkg::POSITION_BITS_DEFAULT,
   parameter int LENGTH_BITS   = bsl_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   bsl_req_if.sink             req_bus,
   input  logic                queue_full,
   output logic                push_valid,
   output bsl_pkg::entry_type  push_entry
);

   localparam int NUM_CAND = 7;

   bsl_pkg::lex_mode_type    mode_ff, mode_in, mode_mid;
   logic [POSITION_BITS-1:0] line_ff, line_in, column_ff, column_in;
   logic [POSITION_BITS-1:0] open_line_ff, open_line_in, open_column_ff, open_column_in;
   logic [LENGTH_BITS-1:0]   open_length_ff, open_length_in, len_inc;

   logic                     accept;
   logic [7:0]               b;
   logic                     eot;
   logic                     digit_hit, is_num, is_term, is_ws, handled;
   bsl_pkg::punct_type       pl;
   logic [4:0]               old_type;
   logic [NUM_CAND-1:0]      cand_v;
   bsl_pkg::record_type      cand [NUM_CAND];
   logic [1:0]               cnt;

   function automatic logic [4:0] mode_type(input bsl_pkg::lex_mode_type m);
      logic [4:0] t;
      case (m)
         bsl_pkg::MODE_NUMBER: t = bsl_pkg::TOK_NUMERAL;
         bsl_pkg::MODE_STRING: t = bsl_pkg::TOK_QUOTED;
         default:              t = bsl_pkg::TOK_SYMBOL;
      endcase
      return t;
   endfunction

   function automatic bsl_pkg::record_type make_rec(input logic kind, input logic [7:0] byt,
                                                    input logic [4:0] typ,
                                                    input logic [31:0] ln,
                                                    input logic [31:0] col,
                                                    input logic [31:0] len);
      bsl_pkg::record_type r;
      r.record_kind  = kind;
      r.token_byte   = byt;
      r.token_type   = typ;
      r.start_line   = bsl_pkg::cap16(ln);
      r.start_column = bsl_pkg::cap16(col);
      r.token_length = bsl_pkg::cap16(len);
      return r;
   endfunction

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.text_byte;
   assign eot           = req_bus.end_of_text;

   assign pl        = bsl_pkg::punct_lookup(b);
   assign digit_hit = (b >= bsl_pkg::CHAR_ZERO) && (b <= bsl_pkg::CHAR_NINE);
   assign is_num    = digit_hit || (b == bsl_pkg::CHAR_DOT);
   assign is_term   = digit_hit || (b == bsl_pkg::CHAR_QUOTE) || (b == bsl_pkg::CHAR_SPACE)
                      || (b == bsl_pkg::CHAR_TAB) || (b == bsl_pkg::CHAR_NEWLINE)
                      || (b == bsl_pkg::CHAR_VTAB) || (b == bsl_pkg::CHAR_RETURN)
                      || (pl.hit && (b != bsl_pkg::CHAR_EQUAL));
   assign is_ws     = (b == bsl_pkg::CHAR_SPACE) || (b == bsl_pkg::CHAR_TAB)
                      || (b == bsl_pkg::CHAR_NEWLINE) || (b == bsl_pkg::CHAR_VTAB)
                      || (b == bsl_pkg::CHAR_FORMFEED) || (b == bsl_pkg::CHAR_RETURN);
   assign old_type  = mode_type(mode_ff);
   assign len_inc   = (open_length_ff == {LENGTH_BITS{1'b1}}) ? open_length_ff
                      : open_length_ff + LENGTH_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= bsl_pkg::MODE_IDLE;
         line_ff        <= POSITION_BITS'(1);
         column_ff      <= POSITION_BITS'(1);
         open_line_ff   <= '0;
         open_column_ff <= '0;
         open_length_ff <= '0;
      end else begin
         mode_ff        <= mode_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
         open_line_ff   <= open_line_in;
         open_column_ff <= open_column_in;
         open_length_ff <= open_length_in;
      end
   end

   always_comb begin
      cand_v         = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         cand[i] = '0;
      end
      mode_mid       = mode_ff;
      open_line_in   = open_line_ff;
      open_column_in = open_column_ff;
      open_length_in = open_length_ff;
      handled        = 1'b0;

      // open token first: continue it, or close it ahead of the byte
      case (mode_ff)
         bsl_pkg::MODE_NUMBER: begin
            if (is_num) begin
               handled        = 1'b1;
               open_length_in = len_inc;
               cand_v[1]      = 1'b1;
               cand[1]        = make_rec(bsl_pkg::REC_TEXT, b, old_type, 32'(open_line_ff),
                                         32'(open_column_ff), 32'(len_inc));
            end else begin
               mode_mid  = bsl_pkg::MODE_IDLE;
               cand_v[0] = 1'b1;
               cand[0]   = make_rec(bsl_pkg::REC_END, 8'h00, old_type, 32'(open_line_ff),
                                    32'(open_column_ff), 32'(open_length_ff));
            end
         end
         bsl_pkg::MODE_SYMBOL: begin
            if (!is_term) begin
               handled        = 1'b1;
               open_length_in = len_inc;
               cand_v[1]      = 1'b1;
               cand[1]        = make_rec(bsl_pkg::REC_TEXT, b, old_type, 32'(open_line_ff),
                                         32'(open_column_ff), 32'(len_inc));
            end else begin
               mode_mid  = bsl_pkg::MODE_IDLE;
               cand_v[0] = 1'b1;
               cand[0]   = make_rec(bsl_pkg::REC_END, 8'h00, old_type, 32'(open_line_ff),
                                    32'(open_column_ff), 32'(open_length_ff));
            end
         end
         bsl_pkg::MODE_STRING: begin
            handled = 1'b1;
            if (b == bsl_pkg::CHAR_QUOTE) begin
               mode_mid  = bsl_pkg::MODE_IDLE;
               cand_v[2] = 1'b1;
               cand[2]   = make_rec(bsl_pkg::REC_END, 8'h00, bsl_pkg::TOK_QUOTED,
                                    32'(open_line_ff), 32'(open_column_ff),
                                    32'(open_length_ff));
            end else begin
               open_length_in = len_inc;
               cand_v[1]      = 1'b1;
               cand[1]        = make_rec(bsl_pkg::REC_TEXT, b, bsl_pkg::TOK_QUOTED,
                                         32'(open_line_ff), 32'(open_column_ff),
                                         32'(len_inc));
            end
         end
         default: ;
      endcase

      // byte seen from idle
      if (!handled) begin
         if (pl.hit) begin
            cand_v[3] = 1'b1;
            cand[3]   = make_rec(bsl_pkg::REC_TEXT, b, pl.code, 32'(line_ff),
                                 32'(column_ff), 32'd1);
            cand_v[4] = 1'b1;
            cand[4]   = make_rec(bsl_pkg::REC_END, 8'h00, pl.code, 32'(line_ff),
                                 32'(column_ff), 32'd1);
         end else if (digit_hit || (!is_ws && (b != bsl_pkg::CHAR_QUOTE))) begin
            mode_mid       = digit_hit ? bsl_pkg::MODE_NUMBER : bsl_pkg::MODE_SYMBOL;
            open_line_in   = line_ff;
            open_column_in = column_ff;
            open_length_in = LENGTH_BITS'(1);
            cand_v[5]      = 1'b1;
            cand[5]        = make_rec(bsl_pkg::REC_TEXT, b,
                                      digit_hit ? bsl_pkg::TOK_NUMERAL : bsl_pkg::TOK_SYMBOL,
                                      32'(line_ff), 32'(column_ff), 32'd1);
         end else if (b == bsl_pkg::CHAR_QUOTE) begin
            mode_mid       = bsl_pkg::MODE_STRING;
            open_line_in   = line_ff;
            open_column_in = column_ff;
            open_length_in = '0;
         end
      end

      // end of text flushes whatever is still open
      if (eot && (mode_mid != bsl_pkg::MODE_IDLE)) begin
         cand_v[6] = 1'b1;
         cand[6]   = make_rec(bsl_pkg::REC_END, 8'h00, mode_type(mode_mid),
                              32'(open_line_in), 32'(open_column_in), 32'(open_length_in));
      end

      // pack the records in order
      cnt             = 2'd0;
      push_entry      = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (cand_v[i] && (cnt != 2'd3)) begin
            push_entry.recs[cnt] = cand[i];
            cnt                  = cnt + 2'd1;
         end
      end
      push_entry.count = cnt;
      push_valid       = accept && (cnt != 2'd0);

      // position counters
      if (b == bsl_pkg::CHAR_NEWLINE) begin
         line_in   = (line_ff == {POSITION_BITS{1'b1}}) ? line_ff
                     : line_ff + POSITION_BITS'(1);
         column_in = POSITION_BITS'(1);
      end else begin
         line_in   = line_ff;
         column_in = (column_ff == {POSITION_BITS{1'b1}}) ? column_ff
                     : column_ff + POSITION_BITS'(1);
      end
      mode_in = mode_mid;
      if (eot) begin
         mode_in   = bsl_pkg::MODE_IDLE;
         line_in   = POSITION_BITS'(1);
         column_in = POSITION_BITS'(1);
      end

      if (!accept) begin
         mode_in        = mode_ff;
         line_in        = line_ff;
         column_in      = column_ff;
         open_line_in   = open_line_ff;
         open_column_in = open_column_ff;
         open_length_in = open_length_ff;
      end
   end

endmodule

FILE: design/bsl_queue.sv
// short record queue between the lexer front and back end
module bsl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  bsl_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output bsl_pkg::entry_type  head_entry,
   output logic                empty
);

   localparam int PTR_BITS = $clog2(bsl_pkg::QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(bsl_pkg::QUEUE_DEPTH - 1);
   localparam logic [PTR_BITS:0]   DEPTH_CNT = (PTR_BITS+1)'(bsl_pkg::QUEUE_DEPTH);

   bsl_pkg::entry_type  entries_ff [bsl_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign empty      = (count_ff == '0);
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue push while full");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");
`endif

endmodule

FILE: design/bsl_back.sv
// lexer back end: walks the records of the queue head out one per transaction
module bsl_back (
   input  logic                clock,
   input  logic                reset,
   input  bsl_pkg::entry_type  head_entry,
   input  logic                empty,
   output logic                pop,
   bsl_rsp_if.source           rsp_bus
);

   logic [1:0]          sub_ff, sub_in;
   logic                last, take;
   bsl_pkg::record_type rec;

   assign rec  = head_entry.recs[sub_ff];
   assign last = (sub_ff == (head_entry.count - 2'd1));
   assign take = rsp_bus.valid && rsp_bus.ready;
   assign pop  = take && last;

   assign rsp_bus.valid        = !empty;
   assign rsp_bus.record_kind  = rec.record_kind;
   assign rsp_bus.token_byte   = rec.token_byte;
   assign rsp_bus.token_type   = rec.token_type;
   assign rsp_bus.start_line   = rec.start_line;
   assign rsp_bus.start_column = rec.start_column;
   assign rsp_bus.token_length = rec.token_length;
   assign rsp_bus.last_of_run  = last;

   always_comb begin
      sub_in = sub_ff;
      if (take) begin
         sub_in = last ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

`ifndef ASSERT_OFF
   a_head_not_empty: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head_entry.count != 2'd0))
      else $error("queue head holds no records");

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (sub_ff < head_entry.count))
      else $error("record index past head count");
`endif

endmodule

FILE: design/byte_stream_lexer.sv
// top level of the byte stream lexer
//
// The lexer takes source text one byte per transaction on req_bus and returns token
// records on rsp_bus: one text record for each byte of token text and one end record
// per token with type, start line, start column and length. A byte causes zero to three
// records; the records of one byte are delivered in consecutive transactions and the
// final one carries last_of_run. Whitespace outside a token and an opening quote cause
// no records of their own. The front end classifies a byte and updates the line,
// column and open-token state in the cycle it is accepted, so bytes can be taken every
// cycle while the queue is not full. Each byte's records go into a four-entry queue as
// one entry, and the back end drives rsp_bus straight from the entry at the queue head.
// req_bus.ready drops only while the queue is full, so the sustained input rate is one
// byte per cycle as long as rsp_bus takes one record per cycle and the text averages no
// more than one record per byte; bursts that produce more are absorbed by the queue.
// Setting end_of_text flushes any open token, unterminated strings included, and returns
// line and column to 1 for the next text. Line, column and length saturate.
module byte_stream_lexer #(
   parameter int POSITION_BITS = bsl_pkg::POSITION_BITS_DEFAULT,
   parameter int LENGTH_BITS   = bsl_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bsl_req_if.sink    req_bus,
   bsl_rsp_if.source  rsp_bus
);

   // front to queue
   logic               push_valid;
   bsl_pkg::entry_type push_entry;
   logic               queue_full;

   // queue to back
   bsl_pkg::entry_type head_entry;
   logic               queue_empty;
   logic               pop;

   // classify bytes and build per-byte record groups
   bsl_front #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouples byte intake from record delivery
   bsl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // one record per output transaction
   bsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: dv/bsl_tb_pkg.sv
`timescale 1ns / 1ps
// token tracker for the byte stream lexer testbench: record type, byte classes and scoreboard
package bsl_tb_pkg;

   typedef struct packed {
      logic        record_kind;
      logic [7:0]  token_byte;
      logic [4:0]  token_type;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] token_length;
      logic        last_of_run;
   } token_record_type;

   function automatic bit is_numeral(logic [7:0] b);
      return b >= bsl_pkg::CHAR_ZERO && b <= bsl_pkg::CHAR_NINE;
   endfunction

   function automatic int punct_code(logic [7:0] b);
      case (b)
         bsl_pkg::CHAR_LPAREN:   return bsl_pkg::TOK_LPAREN;
         bsl_pkg::CHAR_RPAREN:   return bsl_pkg::TOK_RPAREN;
         bsl_pkg::CHAR_LBRACE:   return bsl_pkg::TOK_LBRACE;
         bsl_pkg::CHAR_RBRACE:   return bsl_pkg::TOK_RBRACE;
         bsl_pkg::CHAR_LBRACKET: return bsl_pkg::TOK_LBRACKET;
         bsl_pkg::CHAR_RBRACKET: return bsl_pkg::TOK_RBRACKET;
         bsl_pkg::CHAR_EQUAL:    return bsl_pkg::TOK_ASSIGN;
         bsl_pkg::CHAR_PLUS:     return bsl_pkg::TOK_ADD;
         bsl_pkg::CHAR_MINUS:    return bsl_pkg::TOK_SUB;
         bsl_pkg::CHAR_SLASH:    return bsl_pkg::TOK_DIV;
         bsl_pkg::CHAR_STAR:     return bsl_pkg::TOK_MUL;
         bsl_pkg::CHAR_SEMI:     return bsl_pkg::TOK_SEMI;
         bsl_pkg::CHAR_GREATER:  return bsl_pkg::TOK_GREATER;
         bsl_pkg::CHAR_COMMA:    return bsl_pkg::TOK_SEPARATOR;
         default:                return -1;
      endcase
   endfunction

   // skipped when idle, form feed included
   function automatic bit is_blank(logic [7:0] b);
      return b == bsl_pkg::CHAR_SPACE || b == bsl_pkg::CHAR_TAB ||
             b == bsl_pkg::CHAR_NEWLINE || b == bsl_pkg::CHAR_VTAB ||
             b == bsl_pkg::CHAR_FORMFEED || b == bsl_pkg::CHAR_RETURN;
   endfunction

   // form feed and '=' stay inside a symbol
   function automatic bit ends_symbol(logic [7:0] b);
      return is_numeral(b) || b == bsl_pkg::CHAR_QUOTE ||
             (is_blank(b) && b != bsl_pkg::CHAR_FORMFEED) ||
             (punct_code(b) >= 0 && b != bsl_pkg::CHAR_EQUAL);
   endfunction

   class token_tracker;
      bsl_pkg::lex_mode_type mode;
      logic [15:0]           line_no;
      logic [15:0]           col_no;
      logic [15:0]           tok_line;
      logic [15:0]           tok_col;
      logic [15:0]           tok_len;
      token_record_type      pending_records[$];
      int                    mismatches;
      int                    records_checked;
      int                    tokens_closed;

      function new();
         mode            = bsl_pkg::MODE_IDLE;
         line_no         = 16'd1;
         col_no          = 16'd1;
         tok_line        = '0;
         tok_col         = '0;
         tok_len         = '0;
         mismatches      = 0;
         records_checked = 0;
         tokens_closed   = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function logic [4:0] open_type();
         case (mode)
            bsl_pkg::MODE_NUMBER: return bsl_pkg::TOK_NUMERAL;
            bsl_pkg::MODE_STRING: return bsl_pkg::TOK_QUOTED;
            default:              return bsl_pkg::TOK_SYMBOL;
         endcase
      endfunction

      function void push(logic kind, logic [7:0] b, logic [4:0] ty, logic [15:0] line,
                         logic [15:0] col, logic [15:0] len);
         token_record_type r;
         r.record_kind  = kind;
         r.token_byte   = b;
         r.token_type   = ty;
         r.start_line   = line;
         r.start_column = col;
         r.token_length = len;
         r.last_of_run  = 1'b0;
         pending_records.push_back(r);
      endfunction

      function void open_token(bsl_pkg::lex_mode_type m);
         mode     = m;
         tok_line = line_no;
         tok_col  = col_no;
         tok_len  = '0;
      endfunction

      function void echo(logic [7:0] b);
         tok_len = bump(tok_len);
         push(bsl_pkg::REC_TEXT, b, open_type(), tok_line, tok_col, tok_len);
      endfunction

      function void close_token();
         push(bsl_pkg::REC_END, 8'h00, open_type(), tok_line, tok_col, tok_len);
         mode = bsl_pkg::MODE_IDLE;
         tokens_closed++;
      endfunction

      // predicts the records one accepted byte causes
      function void note_byte(logic [7:0] b, logic eot);
         int               first_idx;
         int               p;
         bit               handled;
         token_record_type r;
         first_idx = pending_records.size();
         handled   = 1'b0;
         case (mode)
            bsl_pkg::MODE_NUMBER: begin
               if (is_numeral(b) || b == bsl_pkg::CHAR_DOT) begin
                  echo(b);
                  handled = 1'b1;
               end else
                  close_token();
            end
            bsl_pkg::MODE_SYMBOL: begin
               if (ends_symbol(b))
                  close_token();
               else begin
                  echo(b);
                  handled = 1'b1;
               end
            end
            bsl_pkg::MODE_STRING: begin
               if (b == bsl_pkg::CHAR_QUOTE)
                  close_token();
               else
                  echo(b);
               handled = 1'b1;
            end
            default: ;
         endcase
         if (!handled) begin
            p = punct_code(b);
            if (p >= 0) begin
               push(bsl_pkg::REC_TEXT, b, p[4:0], line_no, col_no, 16'd1);
               push(bsl_pkg::REC_END, 8'h00, p[4:0], line_no, col_no, 16'd1);
            end else if (is_numeral(b)) begin
               open_token(bsl_pkg::MODE_NUMBER);
               echo(b);
            end else if (b == bsl_pkg::CHAR_QUOTE)
               open_token(bsl_pkg::MODE_STRING);
            else if (!is_blank(b)) begin
               open_token(bsl_pkg::MODE_SYMBOL);
               echo(b);
            end
         end
         if (b == bsl_pkg::CHAR_NEWLINE) begin
            line_no = bump(line_no);
            col_no  = 16'd1;
         end else
            col_no = bump(col_no);
         if (eot) begin
            if (mode != bsl_pkg::MODE_IDLE)
               close_token();
            line_no = 16'd1;
            col_no  = 16'd1;
         end
         if (pending_records.size() > first_idx) begin
            r = pending_records.pop_back();
            r.last_of_run = 1'b1;
            pending_records.push_back(r);
         end
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_record(token_record_type got);
         token_record_type want;
         if (pending_records.size() == 0) begin
            $error("record_kind: expected nothing, got 0x%0h (no record pending)",
                   got.record_kind);
            mismatches++;
            return;
         end
         want = pending_records.pop_front();
         records_checked++;
         check_field("record_kind", 16'(want.record_kind), 16'(got.record_kind));
         check_field("token_byte", 16'(want.token_byte), 16'(got.token_byte));
         check_field("token_type", 16'(want.token_type), 16'(got.token_type));
         check_field("start_line", want.start_line, got.start_line);
         check_field("start_column", want.start_column, got.start_column);
         check_field("token_length", want.token_length, got.token_length);
         check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
      endfunction
   endclass

endpackage

FILE: dv/tb.sv
`timescale 1ns / 1ps
// top level testbench of the byte stream lexer: stimulus, receiver, checking and watchdog
module tb;

   localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either channel
   localparam int LONG_HOLD   = 80;    // receiver hold-off, far longer than the record queue
   localparam int END_WAIT    = 20;    // quiet cycles after the last record to catch extras
   localparam int RANDOM_BYTES = 170;  // random text on top of the directed texts

   // shapes of text the random part strings together
   typedef enum {
      GEN_PUNCT,
      GEN_NUMBER,
      GEN_STRING,
      GEN_SYMBOL,
      GEN_BLANK,
      GEN_NOISE,
      GEN_OPEN_STRING
   } gen_kind_type;

   logic clock = 1'b0;
   logic reset;

   bsl_req_if req_bus ();
   bsl_rsp_if rsp_bus ();

   byte_stream_lexer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bsl_tb_pkg::token_tracker tracker;

   // sender pacing
   int burst_left  = 0;
   bit steady      = 1'b0;
   int bytes_sent  = 0;
   int random_bytes = 0;

   // long receiver hold-off: stimulus bumps the trigger, receiver owns the count
   int hold_trigger = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int rsp_cycle    = 0;

   logic [7:0] text_q[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // receiver: ready pattern cycles through phases of its own, plus the long hold-off
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_cycle++;
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case ((rsp_cycle / 48) % 4)
            0:       rsp_bus.ready <= 1'b1;                     // free flowing
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0); // heavy stalls
         endcase
      end
   end

   // every record transaction is checked against the oldest prediction
   always @(posedge clock) begin
      bsl_tb_pkg::token_record_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.record_kind  = rsp_bus.record_kind;
         got.token_byte   = rsp_bus.token_byte;
         got.token_type   = rsp_bus.token_type;
         got.start_line   = rsp_bus.start_line;
         got.start_column = rsp_bus.start_column;
         got.token_length = rsp_bus.token_length;
         got.last_of_run  = rsp_bus.last_of_run;
         tracker.check_record(got);
      end
   end

   // ---------------------------------------------------------------------------------
   // watchdog: ends the run when neither channel moves for too long
   // ---------------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------------
   task automatic idle_cycles(int n);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // bursts of random length separated by random gaps, unless running steady
   task automatic pace();
      if (burst_left == 0) begin
         if (!steady)
            idle_cycles($urandom_range(1, 8));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // offers one byte and returns at the edge where it is taken
   task automatic send_byte(logic [7:0] b, logic final_byte);
      pace();
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= final_byte;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_byte(b, final_byte);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // stop offering and wait for every predicted record to come out
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_records.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // byte pickers for well-formed random text
   // ---------------------------------------------------------------------------------
   function automatic logic [7:0] punct_char(int i);
      case (i)
         0:       return bsl_pkg::CHAR_LPAREN;
         1:       return bsl_pkg::CHAR_RPAREN;
         2:       return bsl_pkg::CHAR_LBRACE;
         3:       return bsl_pkg::CHAR_RBRACE;
         4:       return bsl_pkg::CHAR_LBRACKET;
         5:       return bsl_pkg::CHAR_RBRACKET;
         6:       return bsl_pkg::CHAR_EQUAL;
         7:       return bsl_pkg::CHAR_PLUS;
         8:       return bsl_pkg::CHAR_MINUS;
         9:       return bsl_pkg::CHAR_SLASH;
         10:      return bsl_pkg::CHAR_STAR;
         11:      return bsl_pkg::CHAR_SEMI;
         12:      return bsl_pkg::CHAR_GREATER;
         default: return bsl_pkg::CHAR_COMMA;
      endcase
   endfunction

   function automatic logic [7:0] blank_char(int i);
      case (i)
         0:       return bsl_pkg::CHAR_SPACE;
         1:       return bsl_pkg::CHAR_TAB;
         2:       return bsl_pkg::CHAR_NEWLINE;
         3:       return bsl_pkg::CHAR_VTAB;
         4:       return bsl_pkg::CHAR_FORMFEED;
         default: return bsl_pkg::CHAR_RETURN;
      endcase
   endfunction

   // any byte that opens a symbol, 0x00 and 0xff included
   function automatic logic [7:0] pick_symbol_head();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (bsl_tb_pkg::ends_symbol(b) || bsl_tb_pkg::is_blank(b) ||
             bsl_tb_pkg::punct_code(b) >= 0);
      return b;
   endfunction

   function automatic logic [7:0] pick_symbol_tail();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (bsl_tb_pkg::ends_symbol(b));
      return b;
   endfunction

   function automatic logic [7:0] pick_string_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == bsl_pkg::CHAR_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] pick_digit();
      return bsl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic append_piece(gen_kind_type kind);
      int n;
      n = 0;
      case (kind)
         GEN_PUNCT:
            text_q.push_back(punct_char($urandom_range(0, 13)));
         GEN_NUMBER: begin
            text_q.push_back(pick_digit());
            n = $urandom_range(0, 6);
            repeat (n)
               text_q.push_back(($urandom_range(0, 3) == 0) ? bsl_pkg::CHAR_DOT
                                                            : pick_digit());
         end
         GEN_STRING: begin
            text_q.push_back(bsl_pkg::CHAR_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) text_q.push_back(pick_string_byte());
            text_q.push_back(bsl_pkg::CHAR_QUOTE);
         end
         GEN_SYMBOL: begin
            text_q.push_back(pick_symbol_head());
            n = $urandom_range(0, 6);
            repeat (n) text_q.push_back(pick_symbol_tail());
         end
         GEN_BLANK: begin
            n = $urandom_range(1, 3);
            repeat (n) text_q.push_back(blank_char($urandom_range(0, 5)));
         end
         GEN_NOISE: begin
            n = $urandom_range(1, 4);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            // opening quote with no closing one, left for end of text to flush
            text_q.push_back(bsl_pkg::CHAR_QUOTE);
            n = $urandom_range(1, 4);
            repeat (n) text_q.push_back(pick_string_byte());
         end
      endcase
   endtask

   // a text is a handful of tokens, mostly well formed, sometimes separated by blanks
   task automatic build_text();
      int tokens;
      int pick;
      gen_kind_type kind;
      text_q.delete();
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1:    kind = GEN_PUNCT;
            2, 3:    kind = GEN_NUMBER;
            4:       kind = GEN_STRING;
            5, 6:    kind = GEN_SYMBOL;
            7:       kind = GEN_BLANK;
            8:       kind = GEN_NOISE;
            default: kind = (t == tokens - 1) ? GEN_OPEN_STRING : GEN_STRING;
         endcase
         append_piece(kind);
         if ($urandom_range(0, 1) == 0 && t != tokens - 1)
            append_piece(GEN_BLANK);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int text_no;
      tracker               = new();
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.text_byte     = 8'h00;
      req_bus.end_of_text   = 1'b0;
      rsp_bus.ready         = 1'b0;
      text_no               = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed text one: symbol of 0x00, '=', form feed and 0xff closed by '(',
      // then every punctuation byte on its own, ending the text on the comma
      send_byte(8'h00, 1'b0);
      send_byte(bsl_pkg::CHAR_EQUAL, 1'b0);
      send_byte(bsl_pkg::CHAR_FORMFEED, 1'b0);
      send_byte(8'hFF, 1'b0);
      for (int i = 0; i < 14; i++)
         send_byte(punct_char(i), i == 13);

      // directed text two: number with a dot cut by a letter, symbol cut by a digit,
      // number cut by a blank, string over a newline, skipped blanks, and an open string
      // flushed by end of text
      send_byte(bsl_pkg::CHAR_ZERO + 8'd7, 1'b0);
      send_byte(bsl_pkg::CHAR_DOT, 1'b0);
      send_byte("x", 1'b0);
      send_byte(bsl_pkg::CHAR_NINE, 1'b0);
      send_byte(bsl_pkg::CHAR_SPACE, 1'b0);
      send_byte(bsl_pkg::CHAR_QUOTE, 1'b0);
      send_byte(bsl_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(bsl_pkg::CHAR_QUOTE, 1'b0);
      send_byte(bsl_pkg::CHAR_RETURN, 1'b0);
      send_byte(bsl_pkg::CHAR_VTAB, 1'b0);
      send_byte(bsl_pkg::CHAR_QUOTE, 1'b0);
      send_byte(bsl_pkg::CHAR_TAB, 1'b1);

      // random texts, each closed by end of text on its last byte
      while (random_bytes < RANDOM_BYTES) begin
         text_no++;
         if (text_no == 2) begin
            // receiver goes away while the sender keeps offering records-heavy bytes,
            // so the record queue fills and the input stalls
            hold_trigger++;
            steady = 1'b1;
            text_q.delete();
            repeat (24) append_piece(GEN_PUNCT);
         end else begin
            if (text_no == 3)
               wait_drained();
            steady = ($urandom_range(0, 3) == 0);
            build_text();
         end
         send_text();
         random_bytes += text_q.size();
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_records.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);

      $display("sent %0d text bytes in %0d random texts; checked %0d records, %0d tokens",
               bytes_sent, text_no, tracker.records_checked, tracker.tokens_closed);
      $display("covered every punctuation byte, open strings flushed at end of text and a %0d-cycle receiver hold",
               LONG_HOLD);
      if (tracker.mismatches == 0 && tracker.pending_records.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
